[hw/rtl/mbgd_pkg.sv]
package mbgd_pkg;

	localparam int MBGD_CHANNELS    = 16;
	localparam int MBGD_MAX_RESULTS = 16;
	localparam int LEVEL_BITS       = 16;
	localparam int TICK_W           = 16;
	localparam int CH_W             = 4;

	localparam logic [TICK_W-1:0] CLICK_WINDOW_RST = 16'd200;
	localparam logic [TICK_W-1:0] HOLD_TIME_RST    = 16'd1000;
	localparam logic [TICK_W-1:0] ELAPSED_MAX      = 16'hFFFF;
	localparam logic [1:0]        EDGE_LIMIT       = 2'd2;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		G_SINGLE  = 2'd0,
		G_DOUBLE  = 2'd1,
		G_HOLD    = 2'd2,
		G_RELEASE = 2'd3
	} gesture_t;

	typedef enum logic {
		CFG_CLICK_WINDOW = 1'b0,
		CFG_HOLD_TIME    = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		op_t                   operation;
		logic [LEVEL_BITS-1:0] levels;
	} item_t;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		gesture_t        gesture;
		logic            last;
	} result_t;

endpackage

[hw/rtl/mbgd_stream_if.sv]
interface mbgd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/multi_button_gesture_detector.sv]
// Channel   Dir  Payload                          Beat when
// item      in   operation, levels                valid & ready
// result    out  channel, gesture, last           valid & ready
// cfg       in   cfg_index, cfg_data              cfg_we
//
// A sample beat is absorbed in the cycle it is accepted; item.ready stays high.
// A tick beat walks the channels one per cycle, unless the result port stalls,
// through one shared increment/compare unit, then enters a flush state.
// The last gesture of a tick is held until the scan ends so last can be set.
// A stalled result port holds the walk only when a second gesture is waiting.
// arst_n clears all channel state and loads the register defaults.
module multi_button_gesture_detector #(
	parameter int CHANNELS = mbgd_pkg::MBGD_CHANNELS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	mbgd_stream_if.sink                      item,
	mbgd_stream_if.source                    result,
	input  logic                             cfg_we,
	input  mbgd_pkg::cfg_index_t             cfg_index,
	input  logic [mbgd_pkg::TICK_W-1:0]      cfg_data
);
	import mbgd_pkg::*;

	localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = $clog2(MBGD_MAX_RESULTS + 1);

	state_t state_q, state_d;

	logic [TICK_W-1:0]     click_window_q, hold_time_q;
	logic [LEVEL_BITS-1:0] prior_q;
	logic                  first_q;
	logic                  active_q  [CHANNELS];
	logic [TICK_W-1:0]     elapsed_q [CHANNELS];
	logic [1:0]            edges_q   [CHANNELS];
	logic                  hold_q    [CHANNELS];

	logic [CW-1:0]    idx_q;
	logic [CNT_W-1:0] cnt_q;
	result_t          pend_q, out_q;
	logic             pend_v_q, out_v_q;

	logic [CHANNELS-1:0] prior_vec, new_vec;
	item_t               in_beat;
	logic                accept, sample_acc, tick_acc;
	logic                cur_act, cur_lvl, fire, report, stall, step, last_idx;
	logic                slot_free, scan_push, flush_push;
	logic [TICK_W-1:0]   e_inc;
	gesture_t            g;

	assign in_beat = item.payload;

	for (genvar i = 0; i < CHANNELS; i++) begin : g_lvl
		if (i < LEVEL_BITS) begin : g_bit
			assign prior_vec[i] = prior_q[i];
			assign new_vec[i]   = in_beat.levels[i];
		end else begin : g_none
			assign prior_vec[i] = 1'b0;
			assign new_vec[i]   = 1'b0;
		end
	end

	assign accept     = item.valid && item.ready;
	assign sample_acc = accept && (in_beat.operation == OP_SAMPLE);
	assign tick_acc   = accept && (in_beat.operation == OP_TICK);

	assign cur_act = active_q[idx_q];
	assign cur_lvl = prior_vec[idx_q];
	assign e_inc   = (elapsed_q[idx_q] != ELAPSED_MAX) ? elapsed_q[idx_q] + 1'b1
	                                                   : elapsed_q[idx_q];

	always_comb begin
		fire = 1'b0;
		g    = G_SINGLE;
		if (cur_act && e_inc >= click_window_q) begin
			if (!cur_lvl) begin
				fire = 1'b1;
				if (edges_q[idx_q] >= EDGE_LIMIT) begin
					g = G_DOUBLE;
				end else if (hold_q[idx_q]) begin
					g = G_RELEASE;
				end else begin
					g = G_SINGLE;
				end
			end else if (e_inc >= hold_time_q) begin
				fire = 1'b1;
				g    = G_HOLD;
			end
		end
	end

	assign slot_free  = !out_v_q || result.ready;
	assign report     = fire && (cnt_q < CNT_W'(MBGD_MAX_RESULTS));
	assign stall      = report && pend_v_q && !slot_free;
	assign step       = (state_q == ST_SCAN) && !stall;
	assign last_idx   = (idx_q == CW'(CHANNELS - 1));
	assign scan_push  = step && report && pend_v_q;
	assign flush_push = (state_q == ST_FLUSH) && pend_v_q && slot_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tick_acc) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (step && last_idx) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!pend_v_q || slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready     = (state_q == ST_IDLE);
		result.valid   = out_v_q;
		result.payload = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			click_window_q <= CLICK_WINDOW_RST;
			hold_time_q    <= HOLD_TIME_RST;
			prior_q        <= '0;
			first_q        <= 1'b1;
			idx_q          <= '0;
			cnt_q          <= '0;
			pend_v_q       <= 1'b0;
			out_v_q        <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				active_q[i]  <= 1'b0;
				elapsed_q[i] <= '0;
				edges_q[i]   <= '0;
				hold_q[i]    <= 1'b0;
			end
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CLICK_WINDOW: click_window_q <= cfg_data;
					CFG_HOLD_TIME:    hold_time_q    <= cfg_data;
					default: ;
				endcase
			end

			if (sample_acc) begin
				first_q <= 1'b0;
				prior_q <= in_beat.levels;
				if (!first_q) begin
					for (int i = 0; i < CHANNELS; i++) begin
						if (new_vec[i] != prior_vec[i]) begin
							elapsed_q[i] <= '0;
							active_q[i]  <= 1'b1;
							if (!new_vec[i] && edges_q[i] < EDGE_LIMIT)
								edges_q[i] <= edges_q[i] + 1'b1;
						end
					end
				end
			end

			if (tick_acc) begin
				idx_q <= '0;
				cnt_q <= '0;
			end

			if (step) begin
				if (!last_idx) idx_q <= idx_q + 1'b1;
				if (cur_act) begin
					elapsed_q[idx_q] <= fire ? '0 : e_inc;
					if (fire) begin
						edges_q[idx_q]   <= '0;
						active_q[idx_q]  <= 1'b0;
						hold_q[idx_q]    <= (g == G_HOLD);
					end
				end
				if (report) begin
					cnt_q    <= cnt_q + 1'b1;
					pend_v_q <= 1'b1;
				end
			end else if (flush_push) begin
				pend_v_q <= 1'b0;
			end

			if (scan_push || flush_push) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && report) begin
			pend_q.channel <= CH_W'(idx_q);
			pend_q.gesture <= g;
			pend_q.last    <= 1'b0;
		end
		if (scan_push) begin
			out_q <= pend_q;
		end else if (flush_push) begin
			out_q <= '{channel: pend_q.channel, gesture: pend_q.gesture, last: 1'b1};
		end
	end

endmodule
